@@ design/assert_macros.svh @@
// assertion macros shared by the haversine distance rtl
// clocked on clk and disabled while rst_n is low in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define HVD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true at a clock edge out of reset
`define HVD_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ design/hvd_pkg.sv @@
// types and constants for the haversine distance pipeline
// no dependencies; used by the channel interfaces and every module
package hvd_pkg;

    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int DIST_W = 28;
    localparam int RAD_W  = 16;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // cordic datapath width, q30 with headroom for the gain
    localparam int CW = 34;
    typedef logic signed [CW-1:0] cvec_t;

    localparam int LANES = 4;

    // register index taken from paddr[2]
    localparam logic REG_RADIUS = 1'b0;

    localparam logic [RAD_W-1:0]  RADIUS_RESET = 16'd6371;
    localparam cvec_t             INV_GAIN     = 34'sd652032874;
    localparam logic [30:0]       Q30_ONE      = 31'h4000_0000;
    localparam logic [30:0]       PI_Q29       = 31'd1686629713;
    localparam logic [29:0]       DIST_MAX     = 30'h0FFF_FFFF;
    localparam logic [26:0]       LAT_TURN     = 27'd23592960;
    localparam logic [26:0]       HALF_TURN    = 27'd47185920;
    // ceil(2^32 / 45), exact quotient for dividends below 2^28
    localparam logic [26:0]       RECIP45      = 27'd95443718;

    // integer square root of a q30 value shifted up by 30
    localparam int SQRT_W     = 62;
    localparam int SQRT_STEPS = 31;

    localparam logic [31:0] ATAN_PHASE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

@@ design/hvd_point_if.sv @@
// channel carrying one pair of positions into the distance pipeline
// depends on hvd_pkg for the field widths
interface hvd_point_if import hvd_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] lat_a;
    logic signed [LON_W-1:0] lon_a;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);

endinterface

@@ design/hvd_dist_if.sv @@
// channel carrying one distance out of the pipeline
// depends on hvd_pkg for the field width
interface hvd_dist_if import hvd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);

endinterface

@@ design/hvd_cordic.sv @@
// unrolled cordic, one micro-rotation per register stage
// rotation or vectoring mode by parameter; depends on hvd_pkg
module hvd_cordic import hvd_pkg::*; #(
    parameter int STEPS     = 24,
    parameter bit VECTORING = 1'b0
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  cvec_t x_in,
    input  cvec_t y_in,
    input  cvec_t z_in,
    input  logic  tag_in,
    output logic  valid_out,
    output cvec_t x_out,
    output cvec_t y_out,
    output cvec_t z_out,
    output logic  tag_out
);

    logic  valid_reg [STEPS];
    logic  tag_reg   [STEPS];
    cvec_t x_reg     [STEPS];
    cvec_t y_reg     [STEPS];
    cvec_t z_reg     [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        logic  vi;
        logic  ti;
        cvec_t xi;
        cvec_t yi;
        cvec_t zi;
        cvec_t xs;
        cvec_t ys;
        cvec_t at;
        logic  dir;
        cvec_t x_next;
        cvec_t y_next;
        cvec_t z_next;

        if (i == 0) begin : g_first
            assign vi = valid_in;
            assign ti = tag_in;
            assign xi = x_in;
            assign yi = y_in;
            assign zi = z_in;
        end else begin : g_chain
            assign vi = valid_reg[i-1];
            assign ti = tag_reg[i-1];
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        assign xs  = xi >>> i;
        assign ys  = yi >>> i;
        assign at  = cvec_t'(ATAN_PHASE[i]);
        // rotation drives z to zero, vectoring drives y to zero
        assign dir = VECTORING ? yi[CW-1] : !zi[CW-1];

        assign x_next = dir ? xi - ys : xi + ys;
        assign y_next = dir ? yi + xs : yi - xs;
        assign z_next = dir ? zi - at : zi + at;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[i] <= ti;
                x_reg[i]   <= x_next;
                y_reg[i]   <= y_next;
                z_reg[i]   <= z_next;
            end
        end
    end

    assign valid_out = valid_reg[STEPS-1];
    assign tag_out   = tag_reg[STEPS-1];
    assign x_out     = x_reg[STEPS-1];
    assign y_out     = y_reg[STEPS-1];
    assign z_out     = z_reg[STEPS-1];

endmodule

@@ design/hvd_isqrt.sv @@
// pipelined floor square root of (value << 30), one result bit per stage
// depends on hvd_pkg for widths and step count
module hvd_isqrt import hvd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        valid_in,
    input  logic [30:0] value,
    output logic        valid_out,
    output logic [30:0] root
);

    logic              valid_reg [SQRT_STEPS];
    logic [SQRT_W-1:0] rem_reg   [SQRT_STEPS];
    logic [SQRT_W-1:0] res_reg   [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SQRT_W-1:0] BIT_K =
            {{(SQRT_W-1){1'b0}}, 1'b1} << (2 * (SQRT_STEPS - 1 - k));

        logic              vi;
        logic [SQRT_W-1:0] rem_i;
        logic [SQRT_W-1:0] res_i;
        logic [SQRT_W-1:0] trial;
        logic              fits;
        logic [SQRT_W-1:0] rem_next;
        logic [SQRT_W-1:0] res_next;

        if (k == 0) begin : g_first
            assign vi    = valid_in;
            assign rem_i = {1'b0, value, 30'd0};
            assign res_i = '0;
        end else begin : g_chain
            assign vi    = valid_reg[k-1];
            assign rem_i = rem_reg[k-1];
            assign res_i = res_reg[k-1];
        end

        assign trial    = res_i + BIT_K;
        assign fits     = rem_i >= trial;
        assign rem_next = fits ? rem_i - trial : rem_i;
        assign res_next = fits ? (res_i >> 1) + BIT_K : res_i >> 1;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign valid_out = valid_reg[SQRT_STEPS-1];
    assign root      = res_reg[SQRT_STEPS-1][30:0];

endmodule

@@ design/haversine_distance.sv @@
// channel     | dir | payload                          | handshake
// points      | in  | lat_a, lon_a, lat_b, lon_b       | valid / ready
// result      | out | distance (1/1024 km, saturating) | valid / ready
// apb         | in  | sphere_radius_km at offset 0     | psel / penable, pready tied high
//
// one transaction per cycle when the sink keeps ready high
// the pipeline runs through four phase stages, two cordic chains,
// four multiply stages, the 31-stage square root and four stages for the scaling
// a stalled output freezes the whole pipeline through one shared enable
// reset clears the valid bits and loads the radius with 6371 km
// depends on hvd_pkg, the two channel interfaces, hvd_cordic and hvd_isqrt
`include "assert_macros.svh"

module haversine_distance import hvd_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    hvd_point_if.sink         points,
    hvd_dist_if.source        result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic en;

    // configuration
    logic [RAD_W-1:0] radius_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_RADIUS);
    assign prdata    = (paddr[2] == REG_RADIUS) ? {{(DATA_W-RAD_W){1'b0}}, radius_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_write)
        begin
            radius_reg <= pwdata[RAD_W-1:0];
        end
    end

    // phase conversion: lanes are lat_a, lat_b, half dlat, half dlon
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [25:0] r1_next [LANES];
    logic [25:0] r1_reg  [LANES];
    logic [20:0] q2_next [LANES];
    logic [20:0] q2_reg  [LANES];
    logic [25:0] r2_reg  [LANES];
    logic [18:0] xm3_next[LANES];
    logic [18:0] xm3_reg [LANES];
    logic [20:0] q3_reg  [LANES];
    logic [31:0] ph_next [LANES];
    logic [31:0] ph_reg  [LANES];

    always_comb
    begin
        logic signed [26:0] ang [LANES];
        logic        [26:0] turn;
        ang[0] = {{3{points.lat_a[LAT_W-1]}}, points.lat_a};
        ang[1] = {{3{points.lat_b[LAT_W-1]}}, points.lat_b};
        ang[2] = {{3{points.lat_b[LAT_W-1]}}, points.lat_b}
               - {{3{points.lat_a[LAT_W-1]}}, points.lat_a};
        ang[3] = {{2{points.lon_b[LON_W-1]}}, points.lon_b}
               - {{2{points.lon_a[LON_W-1]}}, points.lon_a};
        for (int k = 0; k < LANES; k++)
        begin
            turn = (k < 2) ? LAT_TURN : HALF_TURN;
            r1_next[k] = ang[k][26] ? 26'(ang[k] + turn) : ang[k][25:0];
        end
    end

    always_comb
    begin
        logic [52:0] prod;
        for (int k = 0; k < LANES; k++)
        begin
            prod       = {27'd0, r1_reg[k]} * {26'd0, RECIP45};
            q2_next[k] = prod[52:32];
        end
    end

    // split r = 45q + b so the fine part divides a narrow value
    always_comb
    begin
        logic [25:0] q45;
        logic [5:0]  b;
        for (int k = 0; k < LANES; k++)
        begin
            q45 = {5'd0, q2_reg[k]} * 26'd45;
            b   = 6'(r2_reg[k] - q45);
            xm3_next[k] = (k < 2) ? ({b, 13'd0} + 19'd22) : ({1'b0, b, 12'd0} + 19'd22);
        end
    end

    always_comb
    begin
        logic [45:0] prod;
        logic [31:0] hi;
        for (int k = 0; k < LANES; k++)
        begin
            prod       = {27'd0, xm3_reg[k]} * {19'd0, RECIP45};
            hi         = (k < 2) ? 32'({q3_reg[k], 13'd0}) : 32'({q3_reg[k], 12'd0});
            ph_next[k] = hi + {18'd0, prod[45:32]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= points.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg  <= r1_next;
            q2_reg  <= q2_next;
            r2_reg  <= r1_reg;
            xm3_reg <= xm3_next;
            q3_reg  <= q2_reg;
            ph_reg  <= ph_next;
        end
    end

    // sine and cosine, phase folded into [-90, 90) degrees
    logic [LANES-1:0] rot_valid;
    logic             rot_neg [LANES];
    cvec_t            rot_x   [LANES];
    cvec_t            rot_y   [LANES];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic  fold;
        cvec_t z_start;

        assign fold    = ph_reg[k][31] ^ ph_reg[k][30];
        assign z_start = cvec_t'($signed({ph_reg[k][31] ^ fold, ph_reg[k][30:0]}));

        hvd_cordic #(
            .STEPS     (CORDIC_STEPS),
            .VECTORING (1'b0)
        ) u_rot (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (v4_reg),
            .x_in      (INV_GAIN),
            .y_in      ('0),
            .z_in      (z_start),
            .tag_in    (fold),
            .valid_out (rot_valid[k]),
            .x_out     (rot_x[k]),
            .y_out     (rot_y[k]),
            .z_out     (),
            .tag_out   (rot_neg[k])
        );
    end

    // a = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2)
    logic               vm1_reg, vm2_reg, vm3_reg, vm4_reg;
    logic        [33:0] hd_next, hn_next;
    logic        [33:0] hd1_reg, hn1_reg, hd2_reg, hn2_reg, hd3_reg;
    logic signed [65:0] pf_next, pf_reg;
    logic               sg_reg;
    logic signed [33:0] p_next, p_reg;
    logic signed [68:0] prod3_next, prod3_reg;
    logic        [30:0] a_next, na_next, a_reg, na_reg;

    always_comb
    begin
        cvec_t       yd;
        cvec_t       yn;
        logic [63:0] sq_d;
        logic [63:0] sq_n;
        logic signed [65:0] pn;
        logic signed [69:0] s;
        yd      = rot_y[2][CW-1] ? -rot_y[2] : rot_y[2];
        yn      = rot_y[3][CW-1] ? -rot_y[3] : rot_y[3];
        sq_d    = yd[31:0] * yd[31:0];
        sq_n    = yn[31:0] * yn[31:0];
        hd_next = sq_d[63:30];
        hn_next = sq_n[63:30];
        pf_next = $signed(rot_x[0][32:0]) * $signed(rot_x[1][32:0]);

        // cosine sign is applied to the full product before the floor shift
        pn     = sg_reg ? -pf_reg : pf_reg;
        p_next = 34'(pn >>> 30);

        prod3_next = p_reg * $signed({1'b0, hn2_reg});

        s = $signed({36'd0, hd3_reg}) + (prod3_reg >>> 30);
        if (s < 0)
        begin
            a_next = '0;
        end
        else if (s > $signed({39'd0, Q30_ONE}))
        begin
            a_next = Q30_ONE;
        end
        else
        begin
            a_next = s[30:0];
        end
        na_next = Q30_ONE - a_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            vm3_reg <= 1'b0;
            vm4_reg <= 1'b0;
        end
        else if (en)
        begin
            vm1_reg <= &rot_valid;
            vm2_reg <= vm1_reg;
            vm3_reg <= vm2_reg;
            vm4_reg <= vm3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hd1_reg   <= hd_next;
            hn1_reg   <= hn_next;
            pf_reg    <= pf_next;
            sg_reg    <= rot_neg[0] ^ rot_neg[1];
            p_reg     <= p_next;
            hd2_reg   <= hd1_reg;
            hn2_reg   <= hn1_reg;
            prod3_reg <= prod3_next;
            hd3_reg   <= hd2_reg;
            a_reg     <= a_next;
            na_reg    <= na_next;
        end
    end

    // roots of a and 1 - a
    logic        sqa_valid, sqb_valid;
    logic [30:0] rs, rt;

    hvd_isqrt u_sqrt_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (vm4_reg),
        .value     (a_reg),
        .valid_out (sqa_valid),
        .root      (rs)
    );

    hvd_isqrt u_sqrt_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (vm4_reg),
        .value     (na_reg),
        .valid_out (sqb_valid),
        .root      (rt)
    );

    // atan2(rs, rt) by vectoring
    logic  vec_valid;
    cvec_t vec_z;

    hvd_cordic #(
        .STEPS     (CORDIC_STEPS),
        .VECTORING (1'b1)
    ) u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (sqa_valid && sqb_valid),
        .x_in      (cvec_t'({3'd0, rt})),
        .y_in      (cvec_t'({3'd0, rs})),
        .z_in      ('0),
        .tag_in    (1'b0),
        .valid_out (vec_valid),
        .x_out     (),
        .y_out     (),
        .z_out     (vec_z),
        .tag_out   ()
    );

    // distance = radius * theta * pi * 2^29 / 2^49, rounded
    logic              vt_reg, vd1_reg, vd2_reg, out_valid_reg;
    logic [30:0]       theta_next, theta_reg;
    logic [46:0]       m_next, m_reg;
    logic [54:0]       ahi_next, ahi_reg, blo_next, blo_reg;
    logic [DIST_W-1:0] dist_next, dist_reg;

    always_comb
    begin
        logic [55:0] sum;
        if (vec_z < 0)
        begin
            theta_next = '0;
        end
        else if (vec_z > cvec_t'(Q30_ONE))
        begin
            theta_next = Q30_ONE;
        end
        else
        begin
            theta_next = vec_z[30:0];
        end

        m_next   = {31'd0, radius_reg} * {16'd0, theta_reg};
        ahi_next = {31'd0, m_reg[46:23]} * {24'd0, PI_Q29};
        blo_next = {32'd0, m_reg[22:0]} * {24'd0, PI_Q29} + (55'd1 << 48);

        sum       = {1'b0, ahi_reg} + {24'd0, blo_reg[54:23]};
        dist_next = (sum[55:26] > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : sum[DIST_W+25:26];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vt_reg        <= 1'b0;
            vd1_reg       <= 1'b0;
            vd2_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vt_reg        <= vec_valid;
            vd1_reg       <= vt_reg;
            vd2_reg       <= vd1_reg;
            out_valid_reg <= vd2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg <= theta_next;
            m_reg     <= m_next;
            ahi_reg   <= ahi_next;
            blo_reg   <= blo_next;
            dist_reg  <= dist_next;
        end
    end

    // the pipeline moves unless a finished transaction is waiting
    assign en              = !out_valid_reg || result.ready;
    assign points.ready    = en;
    assign result.valid    = out_valid_reg;
    assign result.distance = dist_reg;

    `HVD_ASSERT(a_pair_sums_to_one, vm4_reg |-> (32'(a_reg) + 32'(na_reg) == 32'h4000_0000), "a and 1-a do not add up to one")
    `HVD_ASSERT(theta_held_in_stall, (!en && vt_reg) |=> $stable(theta_reg) && vt_reg, "theta stage moved during a stall")
    `HVD_ASSERT_NEVER(accept_while_blocked, out_valid_reg && !result.ready && points.ready, "input taken while output is blocked")

endmodule
